@@ hw/rtl/ntd_pkg.sv @@
// Shared types, constants and decode functions for the nibble text decoder.
`timescale 1ns / 1ps
`default_nettype none
package ntd_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);
	localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

	localparam int unsigned TABLE_LEN   = 61;
	localparam logic [3:0]  ESC_MIN     = 4'd13;
	localparam logic [7:0]  JOIN_OFFSET = 8'd195;

	localparam logic [7:0] CH_POUND   = 8'hA3;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_BANG    = 8'h21;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_Z   = 8'h7A;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	typedef logic [7:0] char_t;

	// result of decoding one nibble against the escape state
	typedef struct packed {
		logic       vld;
		char_t      ch;
		logic       pend;
		logic [3:0] held;
	} nib_res_t;

	// one classified byte: up to two raw characters, packed to the front
	typedef struct packed {
		logic       last;
		logic [1:0] n_chr;
		char_t      chr_a;
		char_t      chr_b;
	} job_t;

	function automatic char_t char_lut(input logic [5:0] idx);
		char_t c;
		unique case (idx)
			6'd0:  c = 8'h20; // space
			6'd1:  c = 8'h65; // e
			6'd2:  c = 8'h74; // t
			6'd3:  c = 8'h61; // a
			6'd4:  c = 8'h6F; // o
			6'd5:  c = 8'h69; // i
			6'd6:  c = 8'h68; // h
			6'd7:  c = 8'h6E; // n
			6'd8:  c = 8'h73; // s
			6'd9:  c = 8'h72; // r
			6'd10: c = 8'h64; // d
			6'd11: c = 8'h6C; // l
			6'd12: c = 8'h75; // u
			6'd13: c = 8'h6D; // m
			6'd14: c = 8'h77; // w
			6'd15: c = 8'h63; // c
			6'd16: c = 8'h79; // y
			6'd17: c = 8'h66; // f
			6'd18: c = 8'h67; // g
			6'd19: c = 8'h70; // p
			6'd20: c = 8'h62; // b
			6'd21: c = 8'h76; // v
			6'd22: c = 8'h6B; // k
			6'd23: c = 8'h78; // x
			6'd24: c = 8'h6A; // j
			6'd25: c = 8'h71; // q
			6'd26: c = 8'h7A; // z
			6'd27: c = 8'h30;
			6'd28: c = 8'h31;
			6'd29: c = 8'h32;
			6'd30: c = 8'h33;
			6'd31: c = 8'h34;
			6'd32: c = 8'h35;
			6'd33: c = 8'h36;
			6'd34: c = 8'h37;
			6'd35: c = 8'h38;
			6'd36: c = 8'h39;
			6'd37: c = 8'h20; // space
			6'd38: c = 8'h21; // !
			6'd39: c = 8'h3F; // ?
			6'd40: c = 8'h2E; // .
			6'd41: c = 8'h2C; // ,
			6'd42: c = 8'h3A; // :
			6'd43: c = 8'h3B; // ;
			6'd44: c = 8'h28; // (
			6'd45: c = 8'h29; // )
			6'd46: c = 8'h2D; // -
			6'd47: c = 8'h26; // &
			6'd48: c = 8'h2A; // *
			6'd49: c = 8'h5C; // backslash
			6'd50: c = 8'h27; // quote
			6'd51: c = 8'h40; // @
			6'd52: c = 8'h23; // #
			6'd53: c = 8'h2B; // +
			6'd54: c = 8'h3D; // =
			6'd55: c = CH_POUND;
			6'd56: c = 8'h24; // $
			6'd57: c = 8'h25; // %
			6'd58: c = 8'h22; // double quote
			6'd59: c = 8'h5B; // [
			6'd60: c = 8'h5D; // ]
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic nib_res_t decode_nib(input logic pend, input logic [3:0] held,
		input logic [3:0] nib);
		logic [7:0] joined;
		logic [7:0] idx;
		nib_res_t   r;
		joined = {held, nib};
		idx    = joined - JOIN_OFFSET;
		r.vld  = 1'b0;
		r.ch   = 8'h00;
		r.pend = pend;
		r.held = held;
		if (pend) begin
			r.vld  = (joined >= JOIN_OFFSET) && (idx < 8'(TABLE_LEN));
			r.ch   = char_lut(idx[5:0]);
			r.pend = 1'b0;
			r.held = 4'd0;
		end else if (nib < ESC_MIN) begin
			r.vld = 1'b1;
			r.ch  = char_lut({2'b00, nib});
		end else begin
			r.pend = 1'b1;
			r.held = nib;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/nibble_text_decoder_top.sv @@
// A byte's first character passes through the job queue and then into the output register.
// The single output register gives one result beat per cycle while the queue holds jobs and
// out_ready does not stall it; a byte's characters leave one per beat.
// A two-entry job queue lets input beats keep arriving while the output stalls, until it is full.
// Reset (arst_n low, asynchronous) empties the queue and output and clears decode state.
`timescale 1ns / 1ps
`default_nettype none
module nibble_text_decoder_top #(
	parameter int unsigned MAX_CHARS = 100
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] data_byte,
	input  wire logic       msg_last,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic [7:0]      char_code,
	output logic            char_valid,
	output logic            msg_end,
	output logic            out_valid,
	input  wire logic       out_ready
);
	import ntd_pkg::*;

	job_t push_job;
	job_t rd_job;
	logic push;
	logic pop;
	logic q_full;
	logic q_empty;

	ntd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.data_byte(data_byte),
		.msg_last (msg_last),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	ntd_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_job(push_job),
		.pop   (pop),
		.rd_job(rd_job),
		.full  (q_full),
		.empty (q_empty)
	);

	ntd_back #(
		.MAX_CHARS(MAX_CHARS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (rd_job),
		.job_valid (!q_empty),
		.pop       (pop),
		.char_code (char_code),
		.char_valid(char_valid),
		.msg_end   (msg_end),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

`ifndef ASSERT_OFF
	a_empty_beat_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> msg_end && (char_code == 8'h00))
		else $error("empty result beat without message end");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> (char_code != 8'h00))
		else $error("valid character with zero code");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("job queue popped while empty");
`endif

endmodule
`default_nettype wire

@@ hw/rtl/ntd_front.sv @@
// Front end: accepts packed bytes, splits nibbles, resolves escapes into raw characters.
`timescale 1ns / 1ps
`default_nettype none
module ntd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    data_byte,
	input  wire logic          msg_last,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          q_full,
	output logic               push,
	output ntd_pkg::job_t      push_job
);
	import ntd_pkg::*;

	logic       pend_q;
	logic [3:0] held_q;
	nib_res_t   r_hi;
	nib_res_t   r_lo;
	logic       accept;

	always_comb begin
		r_hi = decode_nib(pend_q, held_q, data_byte[7:4]);
		r_lo = decode_nib(r_hi.pend, r_hi.held, data_byte[3:0]);
		push_job.last  = msg_last;
		push_job.n_chr = {1'b0, r_hi.vld} + {1'b0, r_lo.vld};
		push_job.chr_a = r_hi.vld ? r_hi.ch : r_lo.ch;
		push_job.chr_b = r_lo.ch;
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	// a beat with no characters is only pushed when it closes the message
	assign push     = accept && ((push_job.n_chr != 2'd0) || msg_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			held_q <= 4'd0;
		end else if (accept) begin
			if (msg_last) begin
				pend_q <= 1'b0;
				held_q <= 4'd0;
			end else begin
				pend_q <= r_lo.pend;
				held_q <= r_lo.held;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ntd_queue.sv @@
// Small job queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none
module ntd_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire ntd_pkg::job_t wr_job,
	input  wire logic          pop,
	output ntd_pkg::job_t      rd_job,
	output logic               full,
	output logic               empty
);
	import ntd_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full   = (cnt_q == QCNT_W'(QDEPTH));
	assign empty  = (cnt_q == '0);
	assign rd_job = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/ntd_back.sv @@
// Back end: capitalization, character limit and one-character-per-beat output register.
`timescale 1ns / 1ps
`default_nettype none
module ntd_back #(
	parameter int unsigned MAX_CHARS = 100
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire ntd_pkg::job_t job,
	input  wire logic          job_valid,
	output logic               pop,
	output logic [7:0]         char_code,
	output logic               char_valid,
	output logic               msg_end,
	output logic               out_valid,
	input  wire logic          out_ready
);
	import ntd_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_CHARS + 1);

	logic             ph_q;
	logic [CNT_W-1:0] cnt_q;
	logic             cap_q;
	logic             out_valid_q;
	char_t            char_code_q;
	logic             char_valid_q;
	logic             msg_end_q;

	logic  advance;
	char_t cur;
	char_t cap_ch;
	logic  cap_nxt;
	logic  room;
	logic  avail;
	logic  more;
	logic  emit_item;
	logic  end_item;
	logic  is_low;

	always_comb begin
		advance  = job_valid && (!out_valid_q || out_ready);
		cur      = ph_q ? job.chr_b : job.chr_a;
		room     = (cnt_q < CNT_W'(MAX_CHARS));
		avail    = ({1'b0, ph_q} < job.n_chr) && room;
		// second character of the job still fits under the limit
		more     = !ph_q && (job.n_chr == 2'd2) &&
		           (({1'b0, cnt_q} + 1'b1) < (CNT_W + 1)'(MAX_CHARS));
		emit_item = avail || job.last;
		end_item  = job.last && !more;
		pop       = advance && !(avail && more);

		is_low  = (cur >= CH_LOW_A) && (cur <= CH_LOW_Z);
		cap_ch  = cur;
		cap_nxt = cap_q;
		if (cap_q && is_low) begin
			cap_ch  = cur - CASE_DELTA;
			cap_nxt = 1'b0;
		end
		if (cur == CH_DOT || cur == CH_BANG) begin
			cap_nxt = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= 1'b0;
			cnt_q       <= '0;
			cap_q       <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= emit_item;
				ph_q        <= avail && more;
				if (emit_item && end_item) begin
					cnt_q <= '0;
					cap_q <= 1'b1;
				end else if (avail) begin
					cnt_q <= cnt_q + 1'b1;
					cap_q <= cap_nxt;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit_item) begin
			char_code_q  <= avail ? cap_ch : 8'h00;
			char_valid_q <= avail;
			msg_end_q    <= end_item;
		end
	end

	assign out_valid  = out_valid_q;
	assign char_code  = char_code_q;
	assign char_valid = char_valid_q;
	assign msg_end    = msg_end_q;

endmodule
`default_nettype wire
